/* hdl/wildcard_glob_matcher_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the glob matcher.
// Each macro expands to one labeled concurrent assertion on i_clk.
// Checking is held off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("glob matcher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WGM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("glob matcher assertion failed");

`endif

/* hdl/wgm_pkg.sv */
// ---------------------------------------------------------------------------
// wgm_pkg
// Shared constants and types of the glob matcher: wildcard bytes, the
// command item passed from front to back, and status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

    // Wildcard bytes.
    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    // ASCII upper case range for folding.
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] FOLD_OFFSET = 8'h20;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic CFG_IGNORE_CASE = 1'b0;

    // One classified command.
    typedef struct packed {
        logic       subj;   // 1 = subject byte, 0 = pattern byte
        logic       start;  // pattern byte that opens a new pattern
        logic       has;    // byte is valid
        logic       last;   // final byte of pattern or subject
        logic [7:0] ch;     // byte; a subject byte is already case folded if selected
    } t_item;

    // Queue status.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_queue_status;

    // Back-end pipeline status.
    typedef struct packed {
        logic fin_valid;
        logic out_valid;
    } t_back_status;

endpackage

`default_nettype wire

/* hdl/wgm_front.sv */
// ---------------------------------------------------------------------------
// wgm_front
// Accepts input transfers, folds case, tracks whether a new pattern is
// expected and pushes one classified command per transfer into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module wgm_front
    import wgm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_ignore_case,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire logic  i_mode,
    input  wire logic  i_has,
    input  wire logic  i_last,
    input  wire logic [7:0] i_ch,
    input  wire logic  i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    logic r_loading, n_loading;
    logic [7:0] folded;

    // Accept whenever the queue has room.
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // ASCII case folding of subject bytes; pattern bytes are stored raw and
    // folded where they are compared, so a later mode change applies to them.
    always_comb begin
        if (i_mode && i_ignore_case && (i_ch >= UPPER_A) && (i_ch <= UPPER_Z)) begin
            folded = i_ch + FOLD_OFFSET;
        end else begin
            folded = i_ch;
        end
    end

    // Build the command.
    always_comb begin
        o_item.subj  = i_mode;
        o_item.start = !i_mode && r_loading;
        o_item.has   = i_has;
        o_item.last  = i_last;
        o_item.ch    = folded;
    end

    // A pattern byte ends the wait for a new pattern; its last byte restores it.
    always_comb begin
        n_loading = r_loading;
        if (o_push && !i_mode) begin
            n_loading = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading <= 1'b1;
        end else begin
            r_loading <= n_loading;
        end
    end

endmodule

`default_nettype wire

/* hdl/wgm_queue.sv */
// ---------------------------------------------------------------------------
// wgm_queue
// Short first-in first-out queue of commands between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module wgm_queue
    import wgm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output t_queue_status o_stat
);

    t_item r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_item  = r_mem[r_rd];

    // Occupancy follows push and pop.
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/wgm_back.sv */
// ---------------------------------------------------------------------------
// wgm_back
// Holds the pattern and the set of active pattern positions, executes one
// command per cycle unless the finish stage is full, closes the final set over stars and drives the result.
// ---------------------------------------------------------------------------
`default_nettype none

module wgm_back
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_ignore_case,
    input  wire logic  i_q_empty,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic       o_matched,
    output logic       o_overflow,
    output t_back_status o_stat
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [MAX_PATTERN:0] START_SET = (MAX_PATTERN + 1)'(1);

    // Add every position reachable by letting stars match the empty run.
    // Segmented prefix OR in log2 levels: position k inherits from k-d when
    // every byte between them is a star.
    function automatic logic [MAX_PATTERN:0] close_stars(
        input logic [MAX_PATTERN:0]   a,
        input logic [MAX_PATTERN-1:0] s
    );
        logic [MAX_PATTERN:0] g, p, g2, p2;
        int d, k;
        g = a;
        p = {s, 1'b0};
        for (d = 1; d <= MAX_PATTERN; d = d * 2) begin
            g2 = g;
            p2 = p;
            for (k = d; k <= MAX_PATTERN; k++) begin
                g2[k] = g[k] | (p[k] & g[k-d]);
                p2[k] = p[k] & p[k-d];
            end
            g = g2;
            p = p2;
        end
        return g;
    endfunction

    // ASCII case folding of a stored pattern byte.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        if (en && (b >= UPPER_A) && (b <= UPPER_Z)) begin
            return b + FOLD_OFFSET;
        end
        return b;
    endfunction

    logic [7:0] r_pat [MAX_PATTERN];
    logic [LW-1:0] r_len, n_len;
    logic r_ovf, n_ovf;
    logic [MAX_PATTERN:0] r_act, n_act;

    logic [MAX_PATTERN:0]   r_fin_vec;
    logic [MAX_PATTERN-1:0] r_fin_star;
    logic [LW-1:0]          r_fin_len;
    logic                   r_fin_ovf;
    logic                   r_fin_valid, n_fin_valid;

    logic r_out_valid, r_out_match, r_out_ovf;

    logic [MAX_PATTERN-1:0] star, hit;
    logic [MAX_PATTERN:0]   closed, consumed, subj_vec, fin_closed;
    logic [LW-1:0]          base_len;
    logic                   base_ovf, wr_en, fin_load;
    logic                   out_free, fin_free, fin_adv, is_end;

    // Per-position decode of the stored pattern against the current byte.
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            star[j] = (LW'(j) < r_len) && (r_pat[j] == STAR_BYTE);
            hit[j]  = (LW'(j) < r_len) &&
                      ((r_pat[j] == QMARK_BYTE) ||
                       (fold_byte(r_pat[j], i_ignore_case) == i_q_item.ch));
        end
    end

    // One subject byte: close, then step every active position.
    always_comb begin
        closed   = close_stars(r_act, star);
        consumed = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (closed[j] && star[j]) begin
                consumed[j] = 1'b1;
            end
            if (closed[j] && !star[j] && hit[j]) begin
                consumed[j+1] = 1'b1;
            end
        end
        subj_vec = i_q_item.has ? consumed : r_act;
    end

    // Flow control through the finish and output stages.
    assign out_free = !r_out_valid || i_ready;
    assign fin_adv  = r_fin_valid && out_free;
    assign fin_free = !r_fin_valid || out_free;
    assign is_end   = i_q_item.subj && i_q_item.last;
    assign o_q_pop  = !i_q_empty && (!is_end || fin_free);
    assign fin_load = o_q_pop && is_end;

    // Pattern command bookkeeping.
    always_comb begin
        base_len = i_q_item.start ? '0 : r_len;
        base_ovf = i_q_item.start ? 1'b0 : r_ovf;
        wr_en    = 1'b0;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_act    = r_act;
        if (o_q_pop) begin
            if (!i_q_item.subj) begin
                n_len = base_len;
                n_ovf = base_ovf;
                n_act = START_SET;
                if (i_q_item.has) begin
                    if (base_len < LW'(MAX_PATTERN)) begin
                        wr_en = 1'b1;
                        n_len = base_len + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end else begin
                n_act = i_q_item.last ? START_SET : subj_vec;
            end
        end
    end

    // Finish stage occupancy.
    always_comb begin
        n_fin_valid = r_fin_valid;
        if (fin_load) begin
            n_fin_valid = 1'b1;
        end else if (fin_adv) begin
            n_fin_valid = 1'b0;
        end
    end

    assign fin_closed = close_stars(r_fin_vec, r_fin_star);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_act       <= START_SET;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_act       <= n_act;
            r_fin_valid <= n_fin_valid;
            if (fin_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: pattern store, finish snapshot and result.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pat[base_len[PW-1:0]] <= i_q_item.ch;
        end
        if (fin_load) begin
            r_fin_vec  <= subj_vec;
            r_fin_star <= star;
            r_fin_len  <= r_len;
            r_fin_ovf  <= r_ovf;
        end
        if (fin_adv) begin
            r_out_match <= fin_closed[r_fin_len];
            r_out_ovf   <= r_fin_ovf;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_matched        = r_out_match;
    assign o_overflow       = r_out_ovf;
    assign o_stat.fin_valid = r_fin_valid;
    assign o_stat.out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/wildcard_glob_matcher.sv */
// ---------------------------------------------------------------------------
// wildcard_glob_matcher
// Streaming glob matcher for star and question mark wildcards.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one byte per transfer. tdata is the byte, tuser[0]
//   selects pattern (0) or subject (1), tuser[1] marks a valid byte (0 for an
//   empty string), tlast marks the final byte of the pattern or subject.
//   Output stream m_axis: one result per subject tlast transfer; tdata[0] is
//   the match flag, tdata[1] says the pattern was truncated to MAX_PATTERN.
//   APB register 0 (bit 0, reset 1) selects ASCII case folding; the user
//   must write it only while the block is idle, which the block does not enforce.
// Throughput: one transfer per cycle, sustained while the command queue has room, in both
//   modes. The active position vector is updated once per subject byte.
// Path: a tlast transfer is written into the command queue; the back end
//   executes the queue head and loads the finish stage, which then loads
//   the output register that drives the result.
// Reset: the pattern is empty, a new pattern is expected, no result pends.
// Stall: the output register holds its result while m_axis_tready is low;
//   the command queue keeps taking input until it is full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  wire logic        s_axis_tlast,  // last
    input  wire logic [1:0]  s_axis_tuser,  // [0] mode, [1] has_char
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [0] matched, [1] pattern_overflow, zero fill
);

    logic r_ignore_case;
    logic push, pop;
    t_item push_item, pop_item;
    t_queue_status q_stat;
    t_back_status  b_stat;
    logic matched, overflow;

    // Configuration register write and read back.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_case <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[2] == CFG_IGNORE_CASE)) begin
            r_ignore_case <= pwdata[0];
        end
    end

    always_comb begin
        if (paddr[2] == CFG_IGNORE_CASE) begin
            prdata = {31'b0, r_ignore_case};
        end else begin
            prdata = '0;
        end
    end

    // Front: classify and push.
    wgm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ignore_case (r_ignore_case),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_mode        (s_axis_tuser[0]),
        .i_has         (s_axis_tuser[1]),
        .i_last        (s_axis_tlast),
        .i_ch          (s_axis_tdata),
        .i_q_full      (q_stat.full),
        .o_push        (push),
        .o_item        (push_item)
    );

    // Command queue.
    wgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (q_stat)
    );

    // Back: execute and report.
    wgm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ignore_case (r_ignore_case),
        .i_q_empty     (q_stat.empty),
        .i_q_item      (pop_item),
        .o_q_pop       (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_matched     (matched),
        .o_overflow    (overflow),
        .o_stat        (b_stat)
    );

    assign m_axis_tdata = {6'b0, overflow, matched};

    // Consistency checks.
    `WGM_ASSERT_NOW(a_full_count, q_stat.full, q_stat.count == QCNT_W'(QUEUE_DEPTH))
    `WGM_ASSERT_NOW(a_empty_count, q_stat.empty, q_stat.count == '0)
    `WGM_ASSERT_NOW(a_result_from_finish, $rose(m_axis_tvalid), $past(b_stat.fin_valid))
    `WGM_ASSERT_NEXT(a_finish_drains, b_stat.fin_valid && (!m_axis_tvalid || m_axis_tready),
                     m_axis_tvalid)

endmodule

`default_nettype wire

/* dv/wildcard_glob_matcher_checker.sv */
// ---------------------------------------------------------------------------
// Glob matcher scoreboard
// Watches the APB port and both streams of the glob matcher. It keeps its
// own copy of the pattern store, the case folding bit and the set of
// reachable pattern positions, predicts the verdict of every subject, and
// compares each verdict transfer with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_glob_matcher_checker
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    // Input stream
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  wire logic        s_axis_tlast,  // last
    input  wire logic [1:0]  s_axis_tuser,  // [0] mode, [1] has_char
    // Output stream
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,  // [0] matched, [1] pattern_overflow
    // Status to the testbench top
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [2:0] IGNORE_CASE_ADDR = {CFG_IGNORE_CASE, 2'b00};

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // Predicted verdicts, oldest first.
    t_verdict verdicts_due[$];

    // Mirror of the matcher state.
    logic [7:0]         pat_mem [MAX_PATTERN];
    int                 pat_len;
    logic [MAX_PATTERN:0] reach;
    logic               pat_open;
    logic               pat_trunc;
    logic               fold_en;
    int                 fails;

    initial begin
        fails = 0;
    end

    function automatic logic [7:0] fold(input logic [7:0] b);
        if (fold_en && b >= UPPER_A && b <= UPPER_Z) begin
            return b + FOLD_OFFSET;
        end
        return b;
    endfunction

    // A star may match the empty run, so every position after a reachable
    // star is reachable too. Ascending order lets runs of stars chain.
    function automatic logic [MAX_PATTERN:0] star_closure(input logic [MAX_PATTERN:0] s);
        for (int j = 0; j < pat_len; j++) begin
            if (s[j] && pat_mem[j] == STAR_BYTE) begin
                s[j+1] = 1'b1;
            end
        end
        return s;
    endfunction

    // Positions reachable after one more subject byte.
    function automatic logic [MAX_PATTERN:0] advance(input logic [MAX_PATTERN:0] s,
                                                     input logic [7:0] c);
        logic [MAX_PATTERN:0] nxt;
        nxt = '0;
        for (int j = 0; j < pat_len; j++) begin
            if (s[j]) begin
                if (pat_mem[j] == STAR_BYTE) begin
                    nxt[j] = 1'b1;
                end else if (pat_mem[j] == QMARK_BYTE || fold(pat_mem[j]) == c) begin
                    nxt[j+1] = 1'b1;
                end
            end
        end
        return nxt;
    endfunction

    // Apply one accepted input transfer to the mirror.
    task automatic take_item(input logic mode, input logic [7:0] ch,
                             input logic has, input logic last);
        logic [MAX_PATTERN:0] closed;
        t_verdict             v;
        if (!mode) begin
            if (pat_open) begin
                pat_len   = 0;
                pat_trunc = 1'b0;
                pat_open  = 1'b0;
            end
            if (has) begin
                if (pat_len < MAX_PATTERN) begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end else begin
                    pat_trunc = 1'b1;
                end
            end
            if (last) begin
                pat_open = 1'b1;
            end
            // Any pattern byte abandons a subject in progress.
            reach = 1;
        end else begin
            if (has) begin
                reach = advance(star_closure(reach), fold(ch));
            end
            if (last) begin
                closed     = star_closure(reach);
                v.matched  = closed[pat_len];
                v.overflow = pat_trunc;
                verdicts_due.insert(verdicts_due.size(), v);
                reach = 1;
            end
        end
    endtask

    // Compare verdicts first, then track configuration and input.
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        if (!i_rst_n) begin
            pat_len   = 0;
            reach     = 1;
            pat_open  = 1'b1;
            pat_trunc = 1'b0;
            fold_en   = 1'b1;
            verdicts_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata %h",
                             $time, m_axis_tdata);
                    fails++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_axis_tdata[0] !== want.matched) begin
                        $display("%0t: matched mismatch, expected %0b, actual %0b",
                                 $time, want.matched, m_axis_tdata[0]);
                        fails++;
                    end
                    if (m_axis_tdata[1] !== want.overflow) begin
                        $display("%0t: pattern_overflow mismatch, expected %0b, actual %0b",
                                 $time, want.overflow, m_axis_tdata[1]);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == IGNORE_CASE_ADDR) begin
                fold_en = pwdata[0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_item(s_axis_tuser[0], s_axis_tdata, s_axis_tuser[1], s_axis_tlast);
            end
        end
        o_pending    <= verdicts_due.size();
        o_fail_count <= fails;
    end

endmodule

/* dv/wildcard_glob_matcher_tb.sv */
// ---------------------------------------------------------------------------
// Glob matcher testbench
// Drives patterns and subjects into the glob matcher with random gaps and
// output stalls, switches case folding between phases, and reports the
// verdict from the scoreboard's failure count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_glob_matcher_tb;
    import wgm_pkg::*;

    localparam int         MAX_PATTERN      = 32;
    localparam int         RANDOM_ITEMS     = 400;
    localparam int         DRAIN_CYCLES     = 12;
    localparam int         STALL_LIMIT      = 4000;
    localparam logic [2:0] IGNORE_CASE_ADDR = {CFG_IGNORE_CASE, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;  // [7:0] char_code
    logic        s_axis_tlast;  // last
    logic [1:0]  s_axis_tuser;  // [0] mode, [1] has_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // [0] matched, [1] pattern_overflow

    int fail_count;
    int pending;
    int items_sent;
    int stall_cycles;
    bit quiet;

    wildcard_glob_matcher #(.MAX_PATTERN(MAX_PATTERN)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wildcard_glob_matcher_checker #(.MAX_PATTERN(MAX_PATTERN)) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver stalls at random except during the quiet stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);
    end

    // Count cycles in which no transfer of any kind happens.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    // One input transfer; entered and left at a falling edge.
    task automatic send_item(input logic mode, input logic [7:0] ch,
                             input logic has, input logic last);
        while (!quiet && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= {has, mode};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // A whole string; an empty one travels as a single item without a byte.
    task automatic send_text(input logic mode, input string s);
        if (s.len() == 0) begin
            send_item(mode, 8'h00, 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < s.len(); i++) begin
                send_item(mode, s[i], 1'b1, i == s.len() - 1);
            end
        end
    endtask

    // A byte sequence with an occasional empty item slipped in.
    task automatic send_seq(input logic mode, input logic [7:0] seq [$]);
        if (seq.size() == 0) begin
            send_item(mode, 8'($urandom), 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < seq.size(); i++) begin
                if ($urandom_range(99) < 5) begin
                    send_item(mode, 8'($urandom), 1'b0, 1'b0);
                end
                send_item(mode, seq[i], 1'b1, i == seq.size() - 1);
            end
        end
    endtask

    // Stop sending, wait for every verdict, then let the pipeline drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] letters [6] = '{8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h43};
        return letters[$urandom_range(5)];
    endfunction

    function automatic logic [7:0] rand_pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 20) return STAR_BYTE;
        if (r < 35) return QMARK_BYTE;
        if (r < 85) return rand_letter();
        return 8'($urandom);
    endfunction

    initial begin : stimulus
        logic [7:0] pat [$];
        logic [7:0] subj [$];
        logic [7:0] b;
        int         plen;
        int         nsub;
        int         iter;
        int         start;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = '0;
        quiet         = 1'b0;
        items_sent    = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, case folding on after reset.
        send_text(1'b1, "a");      // subject against the empty pattern
        send_text(1'b1, "");       // empty subject, empty pattern
        send_text(1'b0, "A*?");
        send_text(1'b1, "aB");     // folded letter, star on empty run, one byte for '?'
        send_text(1'b1, "x");
        send_text(1'b0, "");       // empty pattern
        send_text(1'b1, "");
        send_item(1'b0, 8'h00, 1'b1, 1'b0);  // zero byte is an ordinary literal
        send_item(1'b0, 8'hFF, 1'b1, 1'b1);
        send_item(1'b1, 8'h00, 1'b1, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1, 1'b1);

        // Exact compare.
        wait_idle();
        apb_write(IGNORE_CASE_ADDR, 32'h0);
        send_text(1'b0, "Ab*");
        send_text(1'b1, "ab");
        send_text(1'b1, "Abzz");
        wait_idle();
        apb_write(IGNORE_CASE_ADDR, 32'h1);

        // Random part: mostly patterns followed by subjects, some raw noise.
        start = items_sent;
        iter  = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            quiet = (iter >= 15 && iter < 35);
            if (iter % 10 == 9) begin
                wait_idle();
                apb_write(IGNORE_CASE_ADDR, 32'($urandom));
            end
            if ($urandom_range(99) < 75) begin
                pat.delete();
                plen = ($urandom_range(99) < 5) ? $urandom_range(40, 30) : $urandom_range(8);
                for (int i = 0; i < plen; i++) begin
                    pat.insert(pat.size(), rand_pattern_byte());
                end
                send_seq(1'b0, pat);
                nsub = $urandom_range(4, 1);
                for (int k = 0; k < nsub; k++) begin
                    subj.delete();
                    if ($urandom_range(99) < 70) begin
                        // Build a subject that the pattern should accept.
                        foreach (pat[i]) begin
                            if (pat[i] == STAR_BYTE) begin
                                repeat ($urandom_range(3)) subj.insert(subj.size(), rand_letter());
                            end else if (pat[i] == QMARK_BYTE) begin
                                subj.insert(subj.size(), ($urandom_range(3) == 0) ? 8'($urandom)
                                                                                  : rand_letter());
                            end else begin
                                b = pat[i];
                                if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
                                    $urandom_range(99) < 30) begin
                                    b = b ^ 8'h20;
                                end
                                subj.insert(subj.size(), b);
                            end
                        end
                        // Sometimes break it.
                        if (subj.size() > 0 && $urandom_range(99) < 20) begin
                            if ($urandom_range(1)) begin
                                subj[$urandom_range(subj.size() - 1)] = rand_letter();
                            end else begin
                                subj.delete($urandom_range(subj.size() - 1));
                            end
                        end
                    end else begin
                        repeat ($urandom_range(8)) subj.insert(subj.size(), rand_letter());
                    end
                    send_seq(1'b1, subj);
                end
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    send_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
                end
            end
            iter++;
        end

        // Let every verdict arrive, then give the block time to settle.
        quiet = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
